### rtl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_cell, sfr_outq and stream_find_replace; depends on nothing.
package sfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int BYTE_W      = 8;
    localparam int WIN_W       = PATTERN_MAX * BYTE_W;
    localparam int REP_W       = 64;
    localparam int BURST_MAX   = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int BURST_W     = BURST_MAX * BYTE_W;
    localparam int LEN_W       = 4;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PATTERN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH  = 2'd3;

    // Broadcast control for the window cells
    typedef struct packed {
        logic              load;
        logic              shift;
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

    // All results caused by one item; byte 0 goes out first
    typedef struct packed {
        logic [BURST_W-1:0] bytes;
        logic [LEN_W-1:0]   cnt;
        logic               mark;   // end marker without a byte
        logic               eos;    // last result carries the end flag
    } t_burst;

endpackage

### rtl/sfr_cell.sv
// One window position: holds a byte, shows it with the incoming byte merged in,
// compares it with its pattern byte and shifts toward the oldest end. Uses sfr_pkg.
module sfr_cell import sfr_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_sel_new,
    input  logic              i_care,
    input  logic [BYTE_W-1:0] i_pat,
    input  logic [BYTE_W-1:0] i_next_v,
    output logic [BYTE_W-1:0] o_v,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_byte;

    assign o_v   = i_sel_new ? i_ctl.data : r_byte;
    assign o_hit = !i_care || (o_v == i_pat);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_next_v;
        end else if (i_ctl.load) begin
            r_byte <= o_v;
        end
    end

endmodule

### rtl/sfr_outq.sv
// Two-slot result queue: slot A drains one byte per cycle while the
// output is ready, slot B holds the next item's results. Uses sfr_pkg.
module sfr_outq import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_burst            i_item,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_present,
    output logic              o_out_end
);

    t_burst r_a, n_a, r_b, n_b;
    logic   r_a_vld, n_a_vld, r_b_vld, n_b_vld;
    logic   a_pop, a_last, a_free;

    assign o_ready       = !r_b_vld;
    assign a_pop         = r_a_vld && i_out_ready;
    assign a_last        = a_pop && (r_a.cnt == LEN_W'(1));
    assign a_free        = !r_a_vld || a_last;

    assign o_out_valid   = r_a_vld;
    assign o_out_byte    = r_a.bytes[BYTE_W-1:0];
    assign o_out_present = !r_a.mark;
    assign o_out_end     = r_a.eos && (r_a.cnt == LEN_W'(1));

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_a_vld = r_a_vld;
        n_b_vld = r_b_vld;
        if (a_pop && !a_last) begin
            n_a.bytes = {{BYTE_W{1'b0}}, r_a.bytes[BURST_W-1:BYTE_W]};
            n_a.cnt   = r_a.cnt - LEN_W'(1);
        end
        if (a_free) begin
            if (r_b_vld) begin
                n_a     = r_b;
                n_a_vld = 1'b1;
                n_b     = i_item;
                n_b_vld = i_push;
            end else begin
                n_a     = i_item;
                n_a_vld = i_push;
            end
        end else if (i_push) begin
            n_b     = i_item;
            n_b_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    a_b_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> r_a_vld)
        else $error("waiting slot full while draining slot empty");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> (r_a.cnt != '0))
        else $error("draining slot valid with no results left");

    a_mark_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && r_a.mark) |-> (r_a.eos && r_a.cnt == LEN_W'(1)))
        else $error("end marker not a lone final result");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_last && r_b_vld) |=> r_a_vld)
        else $error("waiting item not moved up");

endmodule

### rtl/stream_find_replace.sv
// Streaming find-and-replace: top level with the window cell row and result queue.
// Depends on sfr_pkg, sfr_cell and sfr_outq.
//
// Takes one byte item per cycle and rewrites every leftmost, non-overlapping
// occurrence of the configured pattern (up to 8 bytes) with the replacement
// (0 to 8 bytes). Each item is decided in the cycle it is accepted, against a
// row of 8 window cells that compare in parallel and shift toward the oldest
// byte. Its results go into a two-slot queue that sends one result per cycle while
// the output is ready, so a stream of items with at most one result each runs at
// one item per cycle; an item with more results (replacement or end-of-string
// flush) sends them in turn, and the input stalls once both queue slots hold work.
// The user must write registers only while the block is idle; it does not enforce
// this; a pattern length write empties the window. No clearing pass after reset.
module stream_find_replace import sfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_byte_present,
    input  logic                 i_string_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_out_present,
    output logic                 o_out_end,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [WIN_W-1:0] r_pat;
    logic [LEN_W-1:0] r_mlen;
    logic [REP_W-1:0] r_rep;
    logic [LEN_W-1:0] r_rlen;
    logic [LEN_W-1:0] r_fill, n_fill;

    logic [LEN_W-1:0] m_eff, rlen_eff, fill_p;
    logic             accept, active, full, hit;
    t_cell_ctl        ctl;
    t_burst           burst;
    logic             push, q_ready;

    logic [BYTE_W-1:0]      v    [PATTERN_MAX];
    logic [BYTE_W-1:0]      nxt  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hits;
    logic [WIN_W-1:0]       win_v;

    assign m_eff    = (r_mlen > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_mlen;
    assign rlen_eff = (r_rlen > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : r_rlen;
    assign accept = i_in_valid && o_in_ready;
    assign active = (m_eff != '0);
    assign fill_p = r_fill + LEN_W'(i_byte_present);
    assign full   = i_byte_present && (fill_p == m_eff);
    assign hit    = &hits;

    assign ctl.data  = i_data_byte;
    assign ctl.load  = accept && active && i_byte_present;
    assign ctl.shift = accept && active && full && !hit;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        if (g == PATTERN_MAX - 1) begin : g_tail
            assign nxt[g] = '0;
        end else begin : g_link
            assign nxt[g] = v[g+1];
        end
        assign win_v[g*BYTE_W +: BYTE_W] = v[g];

        sfr_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_sel_new (i_byte_present && (r_fill == LEN_W'(g))),
            .i_care    (LEN_W'(g) < m_eff),
            .i_pat     (r_pat[g*BYTE_W +: BYTE_W]),
            .i_next_v  (nxt[g]),
            .o_v       (v[g]),
            .o_hit     (hits[g])
        );
    end

    // Results of the current item
    always_comb begin
        burst.bytes = BURST_W'(win_v);
        burst.mark  = 1'b0;
        burst.eos   = i_string_end;
        if (!active) begin
            burst.bytes = BURST_W'(i_data_byte);
            burst.cnt   = LEN_W'(i_byte_present);
        end else if (full && hit) begin
            burst.bytes = BURST_W'(r_rep);
            burst.cnt   = rlen_eff;
        end else if (full) begin
            // oldest byte out; on end the rest of the window follows it
            burst.cnt = i_string_end ? m_eff : LEN_W'(1);
        end else begin
            burst.cnt = i_string_end ? fill_p : '0;
        end
        if (i_string_end && burst.cnt == '0) begin
            burst.bytes = '0;
            burst.cnt   = LEN_W'(1);
            burst.mark  = 1'b1;
        end
    end

    assign push       = accept && (burst.cnt != '0);
    assign o_in_ready = q_ready;

    always_comb begin
        n_fill = r_fill;
        if (i_cfg_we && i_cfg_index == CFG_MATCH_LENGTH) begin
            n_fill = '0;
        end else if (accept && active) begin
            if (i_string_end || (full && hit)) begin
                n_fill = '0;
            end else if (!full) begin
                n_fill = fill_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_mlen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MATCH_PATTERN:   r_pat  <= WIN_W'(i_cfg_data);
                    CFG_MATCH_LENGTH:    r_mlen <= i_cfg_data[LEN_W-1:0];
                    CFG_REPLACE_PATTERN: r_rep  <= i_cfg_data[REP_W-1:0];
                    CFG_REPLACE_LENGTH:  r_rlen <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    sfr_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_item        (burst),
        .o_ready       (q_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_out_present (o_out_present),
        .o_out_end     (o_out_end)
    );

endmodule
